// File: rtl/lha_pkg.sv
// ----------------------------------------------------------------------------
// lha_pkg
// Shared constants and helpers for the luma histogram accumulator.
// ----------------------------------------------------------------------------
package lha_pkg;

  localparam int COUNT_BITS  = 24;
  localparam int NUM_BINS    = 256;
  localparam int BIN_BITS    = $clog2(NUM_BINS);
  localparam int OUT_BITS    = 24;
  localparam int PIXEL_BITS  = 32;

  // Weighted RGB sum peaks at 255 * 1000 = 255000, which fits in 18 bits
  localparam int SUM_BITS    = 18;
  localparam logic [SUM_BITS-1:0] LUMA_R = SUM_BITS'(299);
  localparam logic [SUM_BITS-1:0] LUMA_G = SUM_BITS'(587);
  localparam logic [SUM_BITS-1:0] LUMA_B = SUM_BITS'(114);

  // Divide by 1000 as multiply by ceil(2^28 / 1000), exact for sums below 493447
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_BITS  = 19;
  localparam logic [RECIP_BITS-1:0] RECIP_1000 = RECIP_BITS'(268436);
  localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic {
    ACT_ACCUM = 1'b0,
    ACT_READ  = 1'b1
  } action_t;

  // Fit a count onto the result port: zero-extend or keep the low bits
  function automatic logic [OUT_BITS-1:0] to_out(input logic [COUNT_BITS-1:0] c);
    logic [OUT_BITS+COUNT_BITS-1:0] wide;
    wide = {{OUT_BITS{1'b0}}, c};
    return wide[OUT_BITS-1:0];
  endfunction

endpackage

// File: rtl/lha_luma.sv
// ----------------------------------------------------------------------------
// lha_luma
// Two-stage brightness pipe: weighted RGB sum, then divide by 1000.
// ----------------------------------------------------------------------------
module lha_luma import lha_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [PIXEL_BITS-1:0] pixel,
  output logic [BIN_BITS-1:0]   luma
);

  logic [SUM_BITS-1:0]  sum;
  logic [SUM_BITS-1:0]  sum_next;
  logic [PROD_BITS-1:0] prod;

  always_comb begin
    sum_next = SUM_BITS'(pixel[23:16]) * LUMA_R
             + SUM_BITS'(pixel[15:8])  * LUMA_G
             + SUM_BITS'(pixel[7:0])   * LUMA_B;
    prod     = PROD_BITS'(sum) * PROD_BITS'(RECIP_1000);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum  <= sum_next;
      luma <= prod[RECIP_SHIFT +: BIN_BITS];
    end
  end

endmodule

// File: rtl/luma_histogram_accumulator.sv
// ----------------------------------------------------------------------------
// luma_histogram_accumulator
// 256-bin brightness histogram of ARGB pixels with saturating counts,
// running peak, end-of-image peak report and single-bin readback.
// ----------------------------------------------------------------------------
//   channel  handshake            fields
//   in       in_valid / in_stall  action, pixel, last_pixel, bin_index
//   out      out_valid/ out_stall bin_count, max_count
//
// One word per cycle in while in_stall is low; after the accept edge a word
// passes the sum, divide and bin RAM read registers, then the update loads the output register.
// Back-to-back hits on one bin are served by forwarding the last write.
// Reset clears a per-bin valid vector and the peak at once; no sweep.
// in_stall rises only while a result word is blocked at the output.
// ----------------------------------------------------------------------------
module luma_histogram_accumulator import lha_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  action,
  input  logic [PIXEL_BITS-1:0] pixel,
  input  logic                  last_pixel,
  input  logic [BIN_BITS-1:0]   bin_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_BITS-1:0]   bin_count,
  output logic [OUT_BITS-1:0]   max_count
);

  logic                  en;
  logic                  res3;

  logic                  valid1, valid2, valid3;
  action_t               action1, action2, action3;
  logic                  last1, last2, last3;
  logic [BIN_BITS-1:0]   idx1, idx2;
  logic [BIN_BITS-1:0]   luma2;
  logic [BIN_BITS-1:0]   addr2, addr3;

  logic [COUNT_BITS-1:0] bin_mem [NUM_BINS];
  logic [NUM_BINS-1:0]   bin_vld;
  logic [COUNT_BITS-1:0] rdata;
  logic                  rd_vld;

  logic                  wr_vld_q;
  logic [BIN_BITS-1:0]   wr_addr_q;
  logic [COUNT_BITS-1:0] wr_data_q;

  logic                  wr_en;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] cnt_next;
  logic [COUNT_BITS-1:0] peak;
  logic [COUNT_BITS-1:0] peak_next;

  lha_luma u_luma (
    .clk   (clk),
    .en    (en),
    .pixel (pixel),
    .luma  (luma2)
  );

  // hold the whole pipe only when a result word cannot leave
  assign res3     = valid3 && (action3 == ACT_READ || last3);
  assign en       = !(out_valid && out_stall && res3);
  assign in_stall = !en;
  assign addr2    = (action2 == ACT_READ) ? idx2 : luma2;

  always_comb begin
    if (wr_vld_q && wr_addr_q == addr3) begin
      cur = wr_data_q;
    end else if (rd_vld) begin
      cur = rdata;
    end else begin
      cur = '0;
    end
    cnt_next  = (cur == COUNT_MAX) ? cur : cur + COUNT_BITS'(1);
    wr_en     = en && valid3 && action3 == ACT_ACCUM;
    peak_next = (valid3 && action3 == ACT_ACCUM && cnt_next > peak) ? cnt_next : peak;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      valid3    <= 1'b0;
      wr_vld_q  <= 1'b0;
      out_valid <= 1'b0;
      peak      <= '0;
      bin_vld   <= '0;
    end else if (en) begin
      valid1    <= in_valid;
      valid2    <= valid1;
      valid3    <= valid2;
      wr_vld_q  <= valid3 && action3 == ACT_ACCUM;
      out_valid <= res3 || (out_valid && out_stall);
      peak      <= peak_next;
      if (wr_en) begin
        bin_vld[addr3] <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      action1   <= action_t'(action);
      last1     <= last_pixel;
      idx1      <= bin_index;
      action2   <= action1;
      last2     <= last1;
      idx2      <= idx1;
      action3   <= action2;
      last3     <= last2;
      addr3     <= addr2;
      wr_addr_q <= addr3;
      wr_data_q <= cnt_next;
      if (res3) begin
        bin_count <= (action3 == ACT_READ) ? to_out(cur) : '0;
        max_count <= to_out(peak_next);
      end
    end
  end

  // bin RAM: one read port, one write port
  always_ff @(posedge clk) begin
    if (en) begin
      rdata  <= bin_mem[addr2];
      rd_vld <= bin_vld[addr2];
    end
    if (wr_en) begin
      bin_mem[addr3] <= cnt_next;
    end
  end

  a_peak_rises: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> peak >= $past(peak))
    else $error("peak count decreased");

  a_peak_covers_write: assert property (@(posedge clk) disable iff (rst)
    wr_vld_q |-> peak >= wr_data_q)
    else $error("peak below a written bin count");

  a_write_nonzero: assert property (@(posedge clk) disable iff (rst)
    wr_vld_q |-> wr_data_q != '0)
    else $error("bin written back as zero");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && valid3)
    else $error("input held without a blocked result");

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: luma histogram accumulator testbench
// Drives accumulate and read words through the valid/stall input channel.
// Every result word is checked field by field against an in-bench copy of
// the histogram or a fixed value. A short directed table runs first,
// then random images with readback. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import lha_pkg::*;

  localparam int HOLD_CYCLES  = 150;
  localparam int RAND_ITEMS   = 850;
  localparam int DRAIN_CYCLES = 12;
  localparam int RUN_LIMIT    = 2_000_000;
  localparam int NUM_ROWS     = 25;

  typedef struct packed {
    logic [OUT_BITS-1:0] bin;
    logic [OUT_BITS-1:0] peak;
  } report_t;

  typedef struct {
    action_t               act;
    logic [PIXEL_BITS-1:0] px;
    logic                  last;
    logic [BIN_BITS-1:0]   idx;
    bit                    fixed;
    logic [OUT_BITS-1:0]   fix_bin;
    logic [OUT_BITS-1:0]   fix_peak;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  action;
  logic [PIXEL_BITS-1:0] pixel;
  logic                  last_pixel;
  logic [BIN_BITS-1:0]   bin_index;
  logic                  out_valid;
  logic                  out_stall;
  logic [OUT_BITS-1:0]   bin_count;
  logic [OUT_BITS-1:0]   max_count;

  report_t               bin_reports [$];
  logic [COUNT_BITS-1:0] hist_bins [NUM_BINS];
  logic [COUNT_BITS-1:0] hist_peak;
  int                    mismatch_cnt = 0;
  int                    burst_left;
  bit                    hold_req;

  stim_row_t dir_tab [NUM_ROWS] = '{
    '{ACT_READ,  32'h0000_0000, 1'b0, 8'd0,   1'b1, 24'd0, 24'd0},
    '{ACT_READ,  32'hFFFF_FFFF, 1'b1, 8'd255, 1'b1, 24'd0, 24'd0},
    '{ACT_ACCUM, 32'hFFFF_FFFF, 1'b1, 8'd0,   1'b1, 24'd0, 24'd1},
    '{ACT_READ,  32'h0000_0000, 1'b0, 8'd255, 1'b1, 24'd1, 24'd1},
    '{ACT_ACCUM, 32'h0000_0000, 1'b0, 8'd0,   1'b0, 24'd0, 24'd0},
    '{ACT_ACCUM, 32'hFF00_0000, 1'b1, 8'd0,   1'b1, 24'd0, 24'd2},
    '{ACT_READ,  32'h0000_0000, 1'b0, 8'd0,   1'b1, 24'd2, 24'd2},
    '{ACT_ACCUM, 32'h00FF_0000, 1'b0, 8'd0,   1'b0, 24'd0, 24'd0},
    '{ACT_ACCUM, 32'h0000_FF00, 1'b0, 8'd0,   1'b0, 24'd0, 24'd0},
    '{ACT_ACCUM, 32'h0000_00FF, 1'b0, 8'd0,   1'b0, 24'd0, 24'd0},
    '{ACT_ACCUM, 32'h0001_0101, 1'b0, 8'd0,   1'b0, 24'd0, 24'd0},
    '{ACT_ACCUM, 32'h0001_0100, 1'b0, 8'd0,   1'b0, 24'd0, 24'd0},
    '{ACT_ACCUM, 32'h80FF_FFFE, 1'b0, 8'd0,   1'b0, 24'd0, 24'd0},
    '{ACT_ACCUM, 32'h0080_8080, 1'b0, 8'd0,   1'b0, 24'd0, 24'd0},
    '{ACT_ACCUM, 32'h0080_8080, 1'b0, 8'd0,   1'b0, 24'd0, 24'd0},
    '{ACT_ACCUM, 32'h0080_8080, 1'b0, 8'd0,   1'b0, 24'd0, 24'd0},
    '{ACT_ACCUM, 32'h0080_8080, 1'b1, 8'd0,   1'b0, 24'd0, 24'd0},
    '{ACT_READ,  32'h5A5A_5A5A, 1'b1, 8'd128, 1'b0, 24'd0, 24'd0},
    '{ACT_READ,  32'h0000_0000, 1'b0, 8'd76,  1'b0, 24'd0, 24'd0},
    '{ACT_READ,  32'h0000_0000, 1'b0, 8'd149, 1'b0, 24'd0, 24'd0},
    '{ACT_READ,  32'h0000_0000, 1'b0, 8'd29,  1'b0, 24'd0, 24'd0},
    '{ACT_READ,  32'h0000_0000, 1'b0, 8'd1,   1'b0, 24'd0, 24'd0},
    '{ACT_ACCUM, 32'hFFFF_FFFF, 1'b0, 8'd0,   1'b0, 24'd0, 24'd0},
    '{ACT_ACCUM, 32'hFFFF_FFFF, 1'b1, 8'd0,   1'b0, 24'd0, 24'd0},
    '{ACT_READ,  32'h0000_0000, 1'b0, 8'd255, 1'b0, 24'd0, 24'd0}
  };

  luma_histogram_accumulator dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .pixel      (pixel),
    .last_pixel (last_pixel),
    .bin_index  (bin_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .bin_count  (bin_count),
    .max_count  (max_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Y = (299R + 587G + 114B) / 1000, truncated
  function automatic logic [BIN_BITS-1:0] luma_bin(input logic [PIXEL_BITS-1:0] px);
    int unsigned sum;
    sum = 32'd299 * px[23:16] + 32'd587 * px[15:8] + 32'd114 * px[7:0];
    return BIN_BITS'(sum / 32'd1000);
  endfunction

  function automatic bit histogram_update(input action_t act,
                                          input logic [PIXEL_BITS-1:0] px,
                                          input logic last,
                                          input logic [BIN_BITS-1:0] idx,
                                          output report_t rpt);
    logic [BIN_BITS-1:0]   y;
    logic [COUNT_BITS-1:0] c;
    rpt = '0;
    if (act == ACT_READ) begin
      rpt.bin  = OUT_BITS'(hist_bins[idx]);
      rpt.peak = OUT_BITS'(hist_peak);
      return 1'b1;
    end
    y = luma_bin(px);
    c = hist_bins[y];
    if (c != COUNT_MAX) c = c + 1'b1;
    hist_bins[y] = c;
    if (c > hist_peak) hist_peak = c;
    if (last) begin
      rpt.peak = OUT_BITS'(hist_peak);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Offer one word and return at its accept edge
  task automatic send_word(input action_t act, input logic [PIXEL_BITS-1:0] px,
                           input logic last, input logic [BIN_BITS-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    in_valid   = 1'b1;
    action     = act;
    pixel      = px;
    last_pixel = last;
    bin_index  = idx;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic issue_word(input action_t act, input logic [PIXEL_BITS-1:0] px,
                            input logic last, input logic [BIN_BITS-1:0] idx,
                            input bit fixed = 1'b0, input report_t fix_rpt = '0);
    report_t rpt;
    bit      has_rpt;
    send_word(act, px, last, idx);
    has_rpt = histogram_update(act, px, last, idx, rpt);
    if (has_rpt) bin_reports.push_back(fixed ? fix_rpt : rpt);
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [PIXEL_BITS-1:0] pick_pixel(input logic [PIXEL_BITS-1:0] prev,
                                                       input logic [PIXEL_BITS-1:0] pal);
    logic [7:0] v;
    v = 8'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4:    return {8'($urandom), pal[23:0]};
      5, 6:    return prev;
      7:       return {8'($urandom), v, v, v};
      default: return {8'($urandom), {8{$urandom_range(0, 1) == 1}},
                       {8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}}};
    endcase
  endfunction

  // Receiver stall pattern, with a long hold-off on request
  initial begin
    int seg_left;
    int mode;
    int phase;
    bit hold_done;
    seg_left  = 0;
    mode      = 0;
    phase     = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        hold_done = 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        phase = (phase + 1) % 5;
        case (mode)
          0:       out_stall = 1'b0;
          1:       out_stall = ($urandom_range(0, 99) < 30);
          2:       out_stall = ($urandom_range(0, 99) < 75);
          default: out_stall = (phase < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (bin_reports.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual bin_count %0d max_count %0d",
                 $time, bin_count, max_count);
        mismatch_cnt++;
      end else begin
        want = bin_reports.pop_front();
        if (bin_count !== want.bin) begin
          $display("%0t: bin_count expected %0d actual %0d", $time, want.bin, bin_count);
          mismatch_cnt++;
        end
        if (max_count !== want.peak) begin
          $display("%0t: max_count expected %0d actual %0d", $time, want.peak, max_count);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("luma_histogram_accumulator: mismatch");
    $finish;
  end

  initial begin
    int                    sent;
    int                    len;
    bit                    held;
    bit                    paused;
    logic [PIXEL_BITS-1:0] prev_px;
    logic [PIXEL_BITS-1:0] pal [4];
    logic [BIN_BITS-1:0]   ridx;
    rst          = 1'b1;
    in_valid     = 1'b0;
    action       = ACT_ACCUM;
    pixel        = '0;
    last_pixel   = 1'b0;
    bin_index    = '0;
    burst_left   = 0;
    hold_req     = 1'b0;
    hist_peak    = '0;
    foreach (hist_bins[i]) hist_bins[i] = '0;
    sent    = 0;
    held    = 1'b0;
    paused  = 1'b0;
    prev_px = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i])
      issue_word(dir_tab[i].act, dir_tab[i].px, dir_tab[i].last, dir_tab[i].idx,
                 dir_tab[i].fixed, '{dir_tab[i].fix_bin, dir_tab[i].fix_peak});

    while (sent < RAND_ITEMS) begin
      if (!held && sent >= 300) begin
        // Block the output and keep offering reads so that the input stalls
        held       = 1'b1;
        hold_req   = 1'b1;
        burst_left = 60;
        repeat (40) begin
          issue_word(ACT_READ, $urandom, 1'($urandom), 8'($urandom));
          sent++;
        end
      end
      if (!paused && sent >= 600) begin
        paused = 1'b1;
        go_idle();
        wait (bin_reports.size() == 0);
      end
      if ($urandom_range(0, 7) == 0) begin
        // Noise: unstructured words, images may be left open
        repeat ($urandom_range(3, 12)) begin
          issue_word(action_t'($urandom_range(0, 1)), $urandom, 1'($urandom), 8'($urandom));
          sent++;
        end
      end else begin
        foreach (pal[i]) pal[i] = $urandom;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        for (int p = 0; p < len; p++) begin
          prev_px = pick_pixel(prev_px, pal[2'($urandom_range(0, 3))]);
          issue_word(ACT_ACCUM, prev_px, p == len - 1, 8'($urandom));
          sent++;
        end
        repeat ($urandom_range(0, 3)) begin
          ridx = ($urandom_range(0, 1) == 1) ? luma_bin(prev_px) : 8'($urandom);
          issue_word(ACT_READ, $urandom, 1'($urandom), ridx);
          sent++;
        end
      end
    end

    go_idle();
    wait (bin_reports.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && bin_reports.size() == 0) begin
      $display("luma_histogram_accumulator: match");
    end else begin
      $display("luma_histogram_accumulator: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/lha_pkg.sv
rtl/lha_luma.sv
rtl/luma_histogram_accumulator.sv
verif/tb.sv
